[rtl/tst_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types of the timeout slot table.
package tst_pkg;

	localparam int SLOTS = 8;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int PADDR_W = 3;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_ADD   = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_SHORT     = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	localparam logic       REG_TICK_PERIOD    = 1'b0;
	localparam logic [9:0] TICK_PERIOD_RESET  = 10'd100;

	typedef struct packed {
		logic [7:0]  handle;
		logic [15:0] timeout_len;
		logic [16:0] elapsed;
	} slot_entry_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		slot_entry_t       entry;
	} slot_wr_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
	} slot_rd_t;

	typedef struct packed {
		logic       fired;
		logic [7:0] fired_handle;
		logic [1:0] status;
		logic [3:0] live_total;
		logic       running;
		logic       last;
	} result_t;

endpackage

[rtl/tst_in_if.sv]
`timescale 1ns / 1ps
// Input channel carrying one command beat of the timeout slot table.
interface tst_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  handle;
	logic [15:0] timeout_len;

	modport source (output valid, kind, handle, timeout_len, input ready);
	modport sink (input valid, kind, handle, timeout_len, output ready);
endinterface

[rtl/tst_out_if.sv]
`timescale 1ns / 1ps
// Output channel carrying one result beat of the timeout slot table.
interface tst_out_if;
	logic       valid;
	logic       ready;
	logic       fired;
	logic [7:0] fired_handle;
	logic [1:0] status;
	logic [3:0] live_total;
	logic       running;
	logic       last;

	modport source (output valid, fired, fired_handle, status, live_total, running, last,
		input ready);
	modport sink (input valid, fired, fired_handle, status, live_total, running, last,
		output ready);
endinterface

[rtl/tst_slot_mem.sv]
`timescale 1ns / 1ps
// Slot memory holding handle, timeout and elapsed time, with registered read data.
module tst_slot_mem
	import tst_pkg::*;
(
	input  logic        clk,
	input  slot_wr_t    wr,
	input  slot_rd_t    rd,
	output slot_entry_t rd_data
);

	slot_entry_t mem [SLOTS];
	slot_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/timeout_slot_table_top.sv]
`timescale 1ns / 1ps
// Top level of the timeout slot table: sequencer, valid bits, counters and APB register.
//
// Commands arrive as beats on in_ch: a tick, an add (handle and timeout) or a clear
// (handle). Results leave as beats on out_ch; the final beat of each command has last
// set. A tick gives one fired beat per expiring slot before its final beat.
// An add, or an unused kind, is decided at once: its result beat is registered from the
// final state, which waits while the output register cannot take it, and in_ch then takes
// the next command. A tick or a clear walks the slot memory one slot per cycle while no
// fired beat is held back: each slot is read and then checked, and a tick writes every
// live slot back with its elapsed time advanced. After the walk its final beat is
// registered from the final state in the same way.
// Results pass through one output register, so the block takes the next command while
// a final beat still waits. When the receiver stalls, a pending fired beat holds the
// walk in place and a final beat holds the sequencer until the register frees.
// The tick_period register sits at byte address 0 of the APB port, written in the
// access cycle; its reset value is 100.
// Reset clears all valid bits and the occupancy count at once; no clearing pass runs.
module timeout_slot_table_top
	import tst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	tst_in_if.sink             in_ch,
	tst_out_if.source          out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINAL
	} state_t;

	state_t            state_q;
	logic [1:0]        op_q;
	logic [7:0]        handle_q;
	logic [1:0]        stat_q;
	logic              found_q;
	logic [CNT_W-1:0]  issue_q;
	logic              v_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [SLOTS-1:0]  valid_q;
	logic [CNT_W-1:0]  count_q;
	logic [9:0]        tick_period_q;
	result_t           out_q;
	logic              out_valid_q;

	slot_entry_t       rd_data;
	slot_wr_t          wr;
	slot_rd_t          rd;

	logic [IDX_W-1:0]  free_idx;
	logic [16:0]       sum;
	logic              slot_live;
	logic              fire;
	logic              hit;
	logic              out_free;
	logic              out_load;
	logic              stall;
	logic              in_acc;
	logic              add_short;
	logic              add_full;
	logic              add_ok;
	logic [CNT_W-1:0]  cnt_dec;
	logic [1:0]        stat_final;

	tst_slot_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign sum       = rd_data.elapsed + 17'(tick_period_q);
	assign slot_live = valid_q[idx_s1];
	assign fire      = v_s1 && (op_q == KIND_TICK) && slot_live
		&& (sum >= {1'b0, rd_data.timeout_len});
	assign hit       = v_s1 && (op_q == KIND_CLEAR) && slot_live && !found_q
		&& (rd_data.handle == handle_q);
	assign out_free  = !out_valid_q || out_ch.ready;
	assign stall     = fire && !out_free;
	assign out_load  = (fire && !stall) || ((state_q == S_FINAL) && out_free);
	assign in_acc    = in_ch.valid && in_ch.ready;
	assign add_short = in_ch.timeout_len < {6'b0, tick_period_q};
	assign add_full  = count_q >= CNT_W'(SLOTS);
	assign add_ok    = !add_short && !add_full;
	assign cnt_dec   = count_q - CNT_W'(1);
	assign stat_final = (op_q == KIND_CLEAR) ? (found_q ? STAT_OK : STAT_NOT_FOUND) : stat_q;

	assign in_ch.ready = (state_q == S_IDLE);

	always_comb begin
		wr = '0;
		if ((state_q == S_SCAN) && v_s1 && (op_q == KIND_TICK) && slot_live && !stall) begin
			wr.en                 = 1'b1;
			wr.addr               = idx_s1;
			wr.entry.handle       = rd_data.handle;
			wr.entry.timeout_len  = rd_data.timeout_len;
			wr.entry.elapsed      = sum;
		end else if (in_acc && (in_ch.kind == KIND_ADD) && add_ok) begin
			wr.en                 = 1'b1;
			wr.addr               = free_idx;
			wr.entry.handle       = in_ch.handle;
			wr.entry.timeout_len  = in_ch.timeout_len;
			wr.entry.elapsed      = '0;
		end
	end

	assign rd.en   = (state_q == S_SCAN) && !stall && (issue_q < CNT_W'(SLOTS));
	assign rd.addr = issue_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= KIND_TICK;
			handle_q      <= '0;
			stat_q        <= STAT_OK;
			found_q       <= 1'b0;
			issue_q       <= '0;
			v_s1          <= 1'b0;
			idx_s1        <= '0;
			valid_q       <= '0;
			count_q       <= '0;
			tick_period_q <= TICK_PERIOD_RESET;
			out_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (psel && penable && pwrite && pready && (paddr[2] == REG_TICK_PERIOD)) begin
				tick_period_q <= pwdata[9:0];
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q     <= in_ch.kind;
						handle_q <= in_ch.handle;
						found_q  <= 1'b0;
						issue_q  <= '0;
						v_s1     <= 1'b0;
						stat_q   <= STAT_OK;
						case (in_ch.kind)
							KIND_TICK, KIND_CLEAR: begin
								state_q <= S_SCAN;
							end
							KIND_ADD: begin
								if (add_short) begin
									stat_q <= STAT_SHORT;
								end else if (add_full) begin
									stat_q <= STAT_FULL;
								end else begin
									valid_q[free_idx] <= 1'b1;
									count_q           <= count_q + CNT_W'(1);
								end
								state_q <= S_FINAL;
							end
							default: begin
								state_q <= S_FINAL;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (!stall) begin
						if (fire) begin
							valid_q[idx_s1]    <= 1'b0;
							count_q            <= cnt_dec;
							out_q.fired        <= 1'b1;
							out_q.fired_handle <= rd_data.handle;
							out_q.status       <= STAT_OK;
							out_q.live_total   <= 4'(cnt_dec);
							out_q.running      <= (cnt_dec != '0);
							out_q.last         <= 1'b0;
						end
						if (hit) begin
							valid_q[idx_s1] <= 1'b0;
							count_q         <= cnt_dec;
							found_q         <= 1'b1;
						end
						if (rd.en) begin
							v_s1    <= 1'b1;
							idx_s1  <= rd.addr;
							issue_q <= issue_q + CNT_W'(1);
						end else begin
							v_s1    <= 1'b0;
							state_q <= S_FINAL;
						end
					end
				end
				S_FINAL: begin
					if (out_free) begin
						out_q.fired        <= 1'b0;
						out_q.fired_handle <= '0;
						out_q.status       <= stat_final;
						out_q.live_total   <= 4'(count_q);
						out_q.running      <= (count_q != '0);
						out_q.last         <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.fired        = out_q.fired;
	assign out_ch.fired_handle = out_q.fired_handle;
	assign out_ch.status       = out_q.status;
	assign out_ch.live_total   = out_q.live_total;
	assign out_ch.running      = out_q.running;
	assign out_ch.last         = out_q.last;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TICK_PERIOD) ? {22'b0, tick_period_q} : '0;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(valid_q)))
		else $error("Occupancy count disagrees with the valid bits.");

	a_pipe_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == S_SCAN))
		else $error("Slot read stage is busy outside a walk.");

	a_fired_beat_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.fired) |-> ((out_q.status == STAT_OK) && !out_q.last))
		else $error("A fired beat carries a status or the last flag.");

	a_final_beat_sent: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FINAL) && out_free) |=> (out_valid_q && out_q.last))
		else $error("The final beat was not placed in the output register.");

	a_add_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_ch.kind == KIND_ADD) && add_ok) |=>
		(count_q == $past(count_q) + CNT_W'(1)))
		else $error("An accepted add did not raise the occupancy count.");

endmodule

[verif/timeout_slot_table_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the timeout slot table: APB set-up, command driver, result checker.
module timeout_slot_table_top_tb;
	import tst_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = SLOTS + 8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  handle;
		logic [15:0] timeout_len;
	} command_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	tst_in_if in_ch();
	tst_out_if out_ch();

	timeout_slot_table_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bit live [SLOTS];
	bit [7:0] owner [SLOTS];
	bit [15:0] limit_ms [SLOTS];
	bit [16:0] age_ms [SLOTS];
	int unsigned occupancy = 0;
	logic [9:0] tick_len = TICK_PERIOD_RESET;

	command_t command_queue[$];
	result_t awaited_results[$];
	command_t next_cmd;
	result_t want;
	int gap_left;
	int stall_left;
	int pause;
	bit quiet = 1'b0;

	int error_count = 0;
	int cycle_count = 0;
	int issued = 0;
	int accepted = 0;
	int tick_count = 0;
	int add_count = 0;
	int clear_count = 0;
	int beat_count = 0;
	int fired_count = 0;
	int setting_count = 1;

	function automatic result_t table_result(input logic fired, input logic [7:0] fh,
		input logic [1:0] status, input logic last_beat);
		result_t r;
		r.fired = fired;
		r.fired_handle = fh;
		r.status = status;
		r.live_total = 4'(occupancy);
		r.running = (occupancy != 0);
		r.last = last_beat;
		return r;
	endfunction

	task automatic advance_table(input command_t c);
		int i;
		logic [1:0] st;
		case (c.kind)
			KIND_TICK: begin
				tick_count++;
				for (i = 0; i < SLOTS; i++) begin
					if (live[i]) begin
						age_ms[i] = age_ms[i] + 17'(tick_len);
						if (age_ms[i] >= 17'(limit_ms[i])) begin
							live[i] = 1'b0;
							occupancy--;
							awaited_results.push_back(table_result(1'b1, owner[i], STAT_OK, 1'b0));
						end
					end
				end
				awaited_results.push_back(table_result(1'b0, 8'd0, STAT_OK, 1'b1));
			end
			KIND_ADD: begin
				add_count++;
				st = STAT_OK;
				if (c.timeout_len < 16'(tick_len)) begin
					st = STAT_SHORT;
				end else if (occupancy >= SLOTS) begin
					st = STAT_FULL;
				end else begin
					for (i = 0; i < SLOTS; i++) begin
						if (!live[i]) begin
							live[i] = 1'b1;
							owner[i] = c.handle;
							limit_ms[i] = c.timeout_len;
							age_ms[i] = '0;
							occupancy++;
							break;
						end
					end
				end
				awaited_results.push_back(table_result(1'b0, 8'd0, st, 1'b1));
			end
			KIND_CLEAR: begin
				clear_count++;
				st = STAT_NOT_FOUND;
				for (i = 0; i < SLOTS; i++) begin
					if (live[i] && owner[i] == c.handle) begin
						live[i] = 1'b0;
						occupancy--;
						st = STAT_OK;
						break;
					end
				end
				awaited_results.push_back(table_result(1'b0, 8'd0, st, 1'b1));
			end
			default: begin
				awaited_results.push_back(table_result(1'b0, 8'd0, STAT_OK, 1'b1));
			end
		endcase
	endtask

	function automatic int draw_pause();
		if (quiet)
			return 0;
		return $urandom_range(0, 6);
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.kind <= KIND_TICK;
			in_ch.handle <= '0;
			in_ch.timeout_len <= '0;
			gap_left <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				advance_table('{in_ch.kind, in_ch.handle, in_ch.timeout_len});
				accepted++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left != 0 || command_queue.size() == 0) begin
					in_ch.valid <= 1'b0;
					if (gap_left != 0)
						gap_left <= gap_left - 1;
				end else begin
					next_cmd = command_queue.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.kind <= next_cmd.kind;
					in_ch.handle <= next_cmd.handle;
					in_ch.timeout_len <= next_cmd.timeout_len;
					gap_left <= draw_pause();
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			pause = stall_left;
			if (out_ch.valid && out_ch.ready) begin
				beat_count++;
				if (awaited_results.size() == 0) begin
					$error("Result beat arrived with no command outstanding");
					error_count++;
				end else begin
					want = awaited_results.pop_front();
					if (want.fired)
						fired_count++;
					check_field("fired", want.fired, out_ch.fired);
					check_field("fired_handle", want.fired_handle, out_ch.fired_handle);
					check_field("status", want.status, out_ch.status);
					check_field("live_total", want.live_total, out_ch.live_total);
					check_field("running", want.running, out_ch.running);
					check_field("last", want.last, out_ch.last);
				end
				pause = draw_pause();
			end
			if (pause != 0) begin
				out_ch.ready <= 1'b0;
				stall_left <= pause - 1;
			end else begin
				out_ch.ready <= 1'b1;
				stall_left <= 0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send(input logic [1:0] kind, input logic [7:0] handle,
		input logic [15:0] tmo);
		while (command_queue.size() >= 2)
			@(posedge clk);
		command_queue.push_back('{kind, handle, tmo});
		issued++;
	endtask

	task automatic wait_quiet();
		do
			@(posedge clk);
		while (issued != accepted || awaited_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tick_period(input logic [9:0] value);
		wait_quiet();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * REG_TICK_PERIOD);
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tick_len = value;
		setting_count++;
	endtask

	function automatic logic [7:0] pick_handle();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 15));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] pick_timeout();
		int unsigned r;
		int unsigned t;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 16'($urandom_range(0, 65535));
		if (r < 25)
			return (tick_len == 0) ? 16'd0 : 16'(tick_len - 1);
		t = tick_len * $urandom_range(1, 6) + $urandom_range(0, tick_len);
		return (t > 65535) ? 16'hFFFF : 16'(t);
	endfunction

	task automatic random_commands(input int count);
		int unsigned r;
		int i;
		int n;
		logic [7:0] h;
		logic [7:0] picks[$];
		n = 0;
		while (n < count) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				repeat (SLOTS + 1) send(KIND_ADD, pick_handle(), pick_timeout());
				n += SLOTS + 1;
			end else if (r < 36) begin
				send(KIND_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
				n++;
			end else if (r < 66) begin
				send(KIND_ADD, pick_handle(), pick_timeout());
				n++;
			end else if (r < 96) begin
				picks.delete();
				for (i = 0; i < SLOTS; i++)
					if (live[i])
						picks.push_back(owner[i]);
				if (picks.size() != 0 && $urandom_range(0, 3) != 0)
					h = picks[$urandom_range(0, picks.size() - 1)];
				else
					h = pick_handle();
				send(KIND_CLEAR, h, 16'($urandom_range(0, 65535)));
				n++;
			end else begin
				send(KIND_UNUSED, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
				n++;
			end
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_TICK;
		in_ch.handle = '0;
		in_ch.timeout_len = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		send(KIND_TICK, 8'd0, 16'd0);
		send(KIND_UNUSED, 8'hFF, 16'hFFFF);
		send(KIND_ADD, 8'h00, 16'd99);
		send(KIND_ADD, 8'hFF, 16'd100);
		send(KIND_ADD, 8'hAA, 16'hFFFF);
		send(KIND_ADD, 8'h55, 16'd250);
		send(KIND_ADD, 8'h55, 16'd300);
		send(KIND_CLEAR, 8'h55, 16'd0);
		send(KIND_CLEAR, 8'h12, 16'd0);
		send(KIND_ADD, 8'h01, 16'd100);
		send(KIND_ADD, 8'h02, 16'd200);
		send(KIND_ADD, 8'h03, 16'd100);
		send(KIND_ADD, 8'h04, 16'd150);
		send(KIND_ADD, 8'h05, 16'd100);
		send(KIND_ADD, 8'h06, 16'd400);
		send(KIND_ADD, 8'h07, 16'd0);
		send(KIND_TICK, 8'd0, 16'd0);
		send(KIND_TICK, 8'd0, 16'd0);
		send(KIND_CLEAR, 8'hAA, 16'd0);
		random_commands(60);

		write_tick_period(10'd0);
		send(KIND_ADD, 8'h09, 16'd0);
		send(KIND_ADD, 8'h0A, 16'hFFFF);
		send(KIND_TICK, 8'd0, 16'd0);
		random_commands(50);

		write_tick_period(10'd1023);
		quiet = 1'b1;
		send(KIND_ADD, 8'h0B, 16'd1022);
		send(KIND_ADD, 8'h0B, 16'd1023);
		send(KIND_TICK, 8'd0, 16'd0);
		random_commands(60);
		wait_quiet();
		quiet = 1'b0;

		write_tick_period(10'd1);
		random_commands(70);

		write_tick_period(10'd1000);
		random_commands(60);

		repeat (2) begin
			write_tick_period(10'($urandom_range(1, 1000)));
			random_commands(55);
		end

		wait_quiet();
		$display("Ran %0d commands (%0d ticks, %0d adds, %0d clears) under %0d tick periods.",
			accepted, tick_count, add_count, clear_count, setting_count);
		$display("Checked %0d result beats, %0d of them expired slots.",
			beat_count, fired_count);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/tst_pkg.sv
rtl/tst_in_if.sv
rtl/tst_out_if.sv
rtl/tst_slot_mem.sv
rtl/timeout_slot_table_top.sv
verif/timeout_slot_table_top_tb.sv
